@@ rtl/sme_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stable matching engine package
// Shared types and constants for the stable matching engine.
// ----------------------------------------------------------------------------
package sme_pkg;

  // Fixed field widths.
  localparam int unsigned IdxW  = 4;
  localparam int unsigned CfgW  = 5;
  localparam int unsigned MaxGroup = 16;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_FIND,
    ST_READ_LIST,
    ST_READ_RANK,
    ST_DECIDE,
    ST_OUT_SEND
  } state_e;

endpackage
`default_nettype wire

@@ rtl/stable_matching_engine_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stable matching engine
// Loads preference tables and runs proposer-optimal deferred acceptance.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one table entry per
//   transaction: a proposer list entry and an acceptor list entry for the
//   same person and rank. Loading runs at one transaction per cycle.
//   An entry with final_entry_i set starts the run: a setup state, then
//   ST_FIND and ST_READ_LIST per proposal, plus ST_READ_RANK and ST_DECIDE
//   when the acceptor already has a partner (both ranks share the one read
//   port), up to N*N proposals, and a last ST_FIND sees all are matched.
//   The N results then leave on the output channel (out_valid_o /
//   out_ready_i), one per ready cycle, proposers in index order; end_of_run_o
//   marks the last one. From the final entry until the last result is
//   taken no new entry is accepted, and a stalled receiver simply holds
//   the current result.
//   group_size_we_i / group_size_i write the group size, which resets to 16.
//   Reset returns the block to loading; the tables stay undefined.
// ----------------------------------------------------------------------------
module stable_matching_engine_unit #(
  parameter int unsigned MaxPeople = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      group_size_we_i,
  input  wire [sme_pkg::CfgW-1:0]  group_size_i,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire [sme_pkg::IdxW-1:0]  person_i,
  input  wire [sme_pkg::IdxW-1:0]  rank_i,
  input  wire [sme_pkg::IdxW-1:0]  proposer_choice_i,
  input  wire [sme_pkg::IdxW-1:0]  acceptor_choice_i,
  input  wire                      final_entry_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output logic [sme_pkg::IdxW-1:0] proposer_index_o,
  output logic [sme_pkg::IdxW-1:0] partner_index_o,
  output logic                     end_of_run_o,
  output logic                     failed_o
);
  import sme_pkg::*;

  localparam int unsigned PW    = (MaxPeople > 1) ? $clog2(MaxPeople) : 1;
  localparam int unsigned AddrW = 2 * PW;
  localparam int unsigned Eff   = (MaxPeople < MaxGroup) ? MaxPeople : MaxGroup;

  // Memories: proposer lists and inverted acceptor lists.
  logic [IdxW-1:0] plist_mem [2**AddrW];
  logic [IdxW-1:0] arank_mem [2**AddrW];

  logic [CfgW-1:0] group_q;
  state_e          state_q, state_d;
  logic [CfgW-1:0] n_q, n_d;
  logic [IdxW-1:0] m_q, m_d;         // current proposer / output index
  logic [IdxW-1:0] w_q, w_d;         // acceptor proposed to
  logic [IdxW-1:0] rank_m_q, rank_m_d;
  logic            failed_q, failed_d;
  logic [MaxGroup-1:0] free_q, free_d, matched_q, matched_d;
  logic [CfgW-1:0] nextp_q [MaxGroup];
  logic [CfgW-1:0] nextp_d [MaxGroup];
  logic [IdxW-1:0] apart_q [MaxGroup];
  logic [IdxW-1:0] apart_d [MaxGroup];

  // Read port and helper signals.
  logic             pl_re, ar_re;
  logic [AddrW-1:0] pl_ra, ar_ra;
  logic [IdxW-1:0]  pl_rd_q, ar_rd_q;
  logic             in_acc, wr_ok;
  logic [IdxW-1:0]  free_sel;
  logic             free_any;
  logic [IdxW-1:0]  partner_sel;
  logic [IdxW-1:0]  cur_partner;
  logic [CfgW-1:0]  m_ext;

  assign in_acc      = in_valid_i && in_ready_o;
  assign wr_ok       = in_acc && (32'(person_i) < MaxPeople) && (32'(rank_i) < MaxPeople);
  assign cur_partner = apart_q[w_q];
  assign m_ext       = CfgW'(m_q);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= CfgW'(MaxGroup);
    end else if (group_size_we_i) begin
      group_q <= group_size_i;
    end
  end

  // Table memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      plist_mem[{PW'(person_i), PW'(rank_i)}] <= proposer_choice_i;
      if (32'(acceptor_choice_i) < MaxPeople) begin
        arank_mem[{PW'(person_i), PW'(acceptor_choice_i)}] <= rank_i;
      end
    end
    if (pl_re) pl_rd_q <= plist_mem[pl_ra];
    if (ar_re) ar_rd_q <= arank_mem[ar_ra];
  end

  // Lowest-indexed free proposer.
  always_comb begin
    free_sel = '0;
    free_any = 1'b0;
    for (int i = MaxGroup - 1; i >= 0; i--) begin
      if (free_q[i] && (CfgW'(i) < n_q)) begin
        free_sel = IdxW'(i);
        free_any = 1'b1;
      end
    end
  end

  // Acceptor holding the proposer being reported.
  always_comb begin
    partner_sel = '0;
    for (int i = MaxGroup - 1; i >= 0; i--) begin
      if (matched_q[i] && (apart_q[i] == m_q)) begin
        partner_sel = IdxW'(i);
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:      if (in_acc && final_entry_i) state_d = ST_INIT;
      ST_INIT:      state_d = ST_FIND;
      ST_FIND: begin
        if (!free_any || (nextp_q[free_sel] >= n_q)) state_d = ST_OUT_SEND;
        else state_d = ST_READ_LIST;
      end
      ST_READ_LIST: begin
        if ((CfgW'(pl_rd_q) >= n_q) || !matched_q[pl_rd_q]) state_d = ST_FIND;
        else state_d = ST_READ_RANK;
      end
      ST_READ_RANK: state_d = ST_DECIDE;
      ST_DECIDE:    state_d = ST_FIND;
      ST_OUT_SEND: begin
        if (out_ready_i && (m_ext + CfgW'(1) == n_q)) state_d = ST_LOAD;
      end
      default:      state_d = ST_LOAD;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    n_d = n_q; m_d = m_q; w_d = w_q; rank_m_d = rank_m_q;
    failed_d = failed_q; free_d = free_q; matched_d = matched_q;
    for (int i = 0; i < MaxGroup; i++) begin
      nextp_d[i] = nextp_q[i];
      apart_d[i] = apart_q[i];
    end
    pl_re = 1'b0; ar_re = 1'b0;
    pl_ra = {PW'(free_sel), PW'(nextp_q[free_sel])};
    ar_ra = {PW'(pl_rd_q), PW'(m_q)};
    case (state_q)
      ST_INIT: begin
        free_d = '1; matched_d = '0; failed_d = 1'b0; m_d = '0;
        if (group_q == '0) n_d = CfgW'(1);
        else if (group_q > CfgW'(Eff)) n_d = CfgW'(Eff);
        else n_d = group_q;
        for (int i = 0; i < MaxGroup; i++) nextp_d[i] = '0;
      end
      ST_FIND: begin
        // Issue the list read for the chosen proposer, or end the run.
        if (!free_any) begin
          m_d = '0;
        end else if (nextp_q[free_sel] >= n_q) begin
          failed_d = 1'b1;
          m_d = '0;
        end else begin
          pl_re = 1'b1;
          m_d = free_sel;
          nextp_d[free_sel] = nextp_q[free_sel] + CfgW'(1);
        end
      end
      ST_READ_LIST: begin
        // A choice beyond the group just uses up the rank.
        if (CfgW'(pl_rd_q) < n_q) begin
          if (!matched_q[pl_rd_q]) begin
            matched_d[pl_rd_q] = 1'b1;
            apart_d[pl_rd_q] = m_q;
            free_d[m_q] = 1'b0;
          end else begin
            w_d = pl_rd_q;
            ar_re = 1'b1;
          end
        end
      end
      ST_READ_RANK: begin
        // Keep the proposer's rank, then read the current partner's rank.
        rank_m_d = ar_rd_q;
        ar_re = 1'b1;
        ar_ra = {PW'(w_q), PW'(cur_partner)};
      end
      ST_DECIDE: begin
        // On equal ranks the acceptor keeps her current partner.
        if (rank_m_q < ar_rd_q) begin
          apart_d[w_q] = m_q;
          free_d[m_q] = 1'b0;
          free_d[cur_partner] = 1'b1;
        end
      end
      ST_OUT_SEND: if (out_ready_i) m_d = m_q + IdxW'(1);
      default: ;
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready_o       = (state_q == ST_LOAD);
    out_valid_o      = (state_q == ST_OUT_SEND);
    proposer_index_o = m_q;
    partner_index_o  = failed_q ? '0 : partner_sel;
    end_of_run_o     = (m_ext + CfgW'(1) == n_q);
    failed_o         = failed_q;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      n_q       <= CfgW'(Eff);
      m_q       <= '0;
      w_q       <= '0;
      rank_m_q  <= '0;
      failed_q  <= 1'b0;
      free_q    <= '1;
      matched_q <= '0;
      for (int i = 0; i < MaxGroup; i++) begin
        nextp_q[i] <= '0;
        apart_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      m_q       <= m_d;
      w_q       <= w_d;
      rank_m_q  <= rank_m_d;
      failed_q  <= failed_d;
      free_q    <= free_d;
      matched_q <= matched_d;
      for (int i = 0; i < MaxGroup; i++) begin
        nextp_q[i] <= nextp_d[i];
        apart_q[i] <= apart_d[i];
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/stable_matching_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable matching engine testbench
// Loads preference tables through the input channel, runs matchings for a
// range of group sizes, and checks every reported partner against an
// in-bench deferred acceptance predictor. Both channels idle at random.
// ----------------------------------------------------------------------------
module stable_matching_engine_unit_tb;
  import sme_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned TotalItems = 370;

  typedef struct packed {
    logic [IdxW-1:0] person;
    logic [IdxW-1:0] rank;
    logic [IdxW-1:0] pchoice;
    logic [IdxW-1:0] achoice;
    logic            fin;
  } entry_t;

  typedef struct packed {
    logic [IdxW-1:0] proposer;
    logic [IdxW-1:0] partner;
    logic            last;
    logic            failed;
  } pairing_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            group_size_we_i = 1'b0;
  logic [CfgW-1:0] group_size_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [IdxW-1:0] person_i = '0;
  logic [IdxW-1:0] rank_i = '0;
  logic [IdxW-1:0] proposer_choice_i = '0;
  logic [IdxW-1:0] acceptor_choice_i = '0;
  logic            final_entry_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [IdxW-1:0] proposer_index_o;
  logic [IdxW-1:0] partner_index_o;
  logic            end_of_run_o;
  logic            failed_o;

  stable_matching_engine_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .group_size_we_i  (group_size_we_i),
    .group_size_i     (group_size_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .person_i         (person_i),
    .rank_i           (rank_i),
    .proposer_choice_i(proposer_choice_i),
    .acceptor_choice_i(acceptor_choice_i),
    .final_entry_i    (final_entry_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .proposer_index_o (proposer_index_o),
    .partner_index_o  (partner_index_o),
    .end_of_run_o     (end_of_run_o),
    .failed_o         (failed_o)
  );

  // Pending entries, expected pairings and the predictor's own tables.
  entry_t          entry_queue[$];
  pairing_t        pairing_queue[$];
  logic [IdxW-1:0] pref_list[MaxGroup][MaxGroup];
  logic [IdxW-1:0] rank_of[MaxGroup][MaxGroup];
  logic [CfgW-1:0] size_reg = 5'd16;
  bit              list_written[MaxGroup][MaxGroup];
  bit              rank_written[MaxGroup][MaxGroup];
  int unsigned     error_count = 0;
  int unsigned     items_made = 0;
  int unsigned     items_taken = 0;
  int unsigned     send_gap = 0;
  int unsigned     recv_hold = 0;
  bit              quiet_mode = 1'b0;
  bit              long_hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned active_size(logic [CfgW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxGroup) return MaxGroup;
    return v;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Store one entry and, on the final one, run deferred acceptance.
  task automatic predict_matching(entry_t e);
    int unsigned n, m, w, nfree, partner;
    int unsigned next_rank[MaxGroup];
    logic [IdxW-1:0] mate[MaxGroup];
    bit taken[MaxGroup];
    bit is_free[MaxGroup];
    bit ok;
    pairing_t p;
    pref_list[e.person][e.rank] = e.pchoice;
    rank_of[e.person][e.achoice] = e.rank;
    if (!e.fin) return;
    n = active_size(size_reg);
    for (int i = 0; i < MaxGroup; i++) begin
      next_rank[i] = 0;
      mate[i] = '0;
      taken[i] = 1'b0;
      is_free[i] = 1'b1;
    end
    ok = 1'b1;
    nfree = n;
    while (nfree > 0 && ok) begin
      m = 0;
      while (m < n && !is_free[m]) m++;
      if (m >= n || next_rank[m] >= n) begin
        ok = 1'b0;
      end else begin
        w = pref_list[m][next_rank[m]];
        next_rank[m]++;
        if (w < n) begin
          if (!taken[w]) begin
            mate[w] = IdxW'(m);
            taken[w] = 1'b1;
            is_free[m] = 1'b0;
            nfree--;
          end else if (rank_of[w][m] < rank_of[w][mate[w]]) begin
            is_free[mate[w]] = 1'b1;
            mate[w] = IdxW'(m);
            is_free[m] = 1'b0;
          end
        end
      end
    end
    for (m = 0; m < n; m++) begin
      partner = 0;
      if (ok) begin
        for (w = 0; w < n; w++) begin
          if (taken[w] && mate[w] == m) begin
            partner = w;
            break;
          end
        end
      end
      p.proposer = IdxW'(m);
      p.partner = IdxW'(partner);
      p.last = (m + 1 == n);
      p.failed = !ok;
      pairing_queue.push_back(p);
    end
  endtask

  // Driver: presents queued entries with random gaps between transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    entry_t e;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (entry_queue.size() > 0) begin
        e = entry_queue.pop_front();
        person_i <= e.person;
        rank_i <= e.rank;
        proposer_choice_i <= e.pchoice;
        acceptor_choice_i <= e.achoice;
        final_entry_i <= e.fin;
        in_valid_i <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Input monitor: every accepted entry updates the predictor.
  always @(posedge clk_i) begin
    entry_t e;
    if (rst_ni && in_valid_i && in_ready_o) begin
      e.person = person_i;
      e.rank = rank_i;
      e.pchoice = proposer_choice_i;
      e.achoice = acceptor_choice_i;
      e.fin = final_entry_i;
      predict_matching(e);
      items_taken++;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_hold = 0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      recv_hold = 400;
      out_ready_i <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      recv_hold = pick_gap();
    end
  end

  // Output monitor: compare each accepted transaction with the oldest pairing.
  always @(posedge clk_i) begin
    pairing_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pairing_queue.size() == 0) begin
        report("unexpected result, proposer", proposer_index_o, 0);
      end else begin
        want = pairing_queue.pop_front();
        if (proposer_index_o !== want.proposer)
          report("proposer_index", proposer_index_o, want.proposer);
        if (partner_index_o !== want.partner)
          report("partner_index", partner_index_o, want.partner);
        if (end_of_run_o !== want.last)
          report("end_of_run", end_of_run_o, want.last);
        if (failed_o !== want.failed)
          report("failed", failed_o, want.failed);
      end
    end
  end

  // Watchdog.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("stable_matching_engine_unit_tb: errors");
    $finish;
  end

  task automatic push_entry(int unsigned p, int unsigned r, int unsigned pc, int unsigned ac,
                            bit fin);
    entry_t e;
    e.person = IdxW'(p);
    e.rank = IdxW'(r);
    e.pchoice = IdxW'(pc);
    e.achoice = IdxW'(ac);
    e.fin = fin;
    list_written[p][r] = 1'b1;
    rank_written[p][ac] = 1'b1;
    entry_queue.push_back(e);
    items_made++;
  endtask

  // Wait until every entry is taken, every result is back and the block
  // accepts input again.
  task automatic wait_idle();
    while (items_taken < items_made || pairing_queue.size() > 0 || !in_ready_o)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_size(int unsigned v);
    @(posedge clk_i);
    group_size_we_i <= 1'b1;
    group_size_i <= CfgW'(v);
    @(posedge clk_i);
    group_size_we_i <= 1'b0;
    size_reg = CfgW'(v);
  endtask

  // Build one run: 0 = permutation tables, 1 = random noise, 2 = damaged
  // permutations. Any table cell the run will read is written first.
  task automatic make_run(int unsigned n, int unsigned mode);
    int unsigned plist[MaxGroup], alist[MaxGroup];
    int unsigned j, t, count;
    if (mode == 1) begin
      count = $urandom_range(1, n * 2);
      repeat (count)
        push_entry($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), 1'b0);
    end else begin
      for (int p = 0; p < n; p++) begin
        for (int i = 0; i < n; i++) begin
          plist[i] = i;
          alist[i] = i;
        end
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = plist[i]; plist[i] = plist[j]; plist[j] = t;
          j = $urandom_range(0, i);
          t = alist[i]; alist[i] = alist[j]; alist[j] = t;
        end
        for (int r = 0; r < n; r++) begin
          if (mode == 2 && $urandom_range(0, 5) == 0)
            push_entry(p, r, $urandom_range(0, 15), $urandom_range(0, n - 1), 1'b0);
          else
            push_entry(p, r, plist[r], alist[r], 1'b0);
        end
      end
    end
    for (int p = 0; p < n; p++)
      for (int r = 0; r < n; r++)
        if (!list_written[p][r])
          push_entry(p, r, $urandom_range(0, n - 1), p, 1'b0);
    for (int w = 0; w < n; w++)
      for (int m = 0; m < n; m++)
        if (!rank_written[w][m])
          push_entry(w, $urandom_range(0, 15), $urandom_range(0, 15), m, 1'b0);
    if (entry_queue.size() == 0)
      push_entry(0, 0, pref_list[0][0], 0, 1'b0);
    entry_queue[$].fin = 1'b1;
  endtask

  // Stimulus phases.
  initial begin
    int unsigned v, n, mode;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Smallest group: a single proposer matched to the single acceptor.
    write_size(1);
    push_entry(0, 0, 0, 0, 1'b1);
    wait_idle();

    // Group size zero acts as one; the only choice is beyond the group,
    // so the proposer runs out of choices and the run fails.
    write_size(0);
    push_entry(0, 0, 1, 0, 1'b1);
    wait_idle();

    // Two people where acceptor 0 ranks both proposers equally: she keeps
    // her first partner.
    write_size(2);
    push_entry(0, 1, 1, 1, 1'b0);
    push_entry(0, 0, 0, 0, 1'b0);
    push_entry(0, 0, 0, 1, 1'b0);
    push_entry(1, 0, 0, 0, 1'b0);
    push_entry(1, 1, 1, 1, 1'b1);
    wait_idle();

    // Full sized tables at the reset-time size limit.
    write_size(16);
    make_run(16, 0);
    wait_idle();

    // Two runs back to back with the receiver held off, so input stalls.
    write_size(3);
    long_hold_req = 1'b1;
    make_run(3, 0);
    make_run(3, 1);
    wait_idle();

    // Random runs over sizes one to five and sixteen, mostly small and well formed.
    while (items_made < TotalItems) begin
      quiet_mode = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: v = 0;
        1: v = $urandom_range(16, 31);
        default: v = $urandom_range(1, 5);
      endcase
      write_size(v);
      n = active_size(v);
      mode = $urandom_range(0, 9);
      mode = (mode < 7) ? 0 : (mode < 9 ? 2 : 1);
      if (n > 6) mode = 1;
      make_run(n, mode);
      // Back-to-back run with the receiver held off, so input stalls.
      if (!long_hold_req && $urandom_range(0, 9) == 0) begin
        long_hold_req = 1'b1;
        make_run(n, 1);
      end
      wait_idle();
    end

    wait_idle();
    if (error_count == 0)
      $display("stable_matching_engine_unit_tb: clean");
    else
      $display("stable_matching_engine_unit_tb: errors");
    $finish;
  end

endmodule
